FILE: hw/rtl/aes_pkg.sv
// Shared AES types, tables and byte-level GF(2^8) functions.
package aes_pkg;

  typedef struct packed {
    logic dec;
    logic full;
    logic last;
  } round_ctrl_t;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2,
    KEY_RSV = 2'd3
  } key_size_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_SIZE = 3'd4,
    REG_MODE = 3'd5
  } reg_index_t;

  localparam int NumRoundKeys = 15;
  localparam int NumWords = 60;
  localparam logic [7:0] Poly = 8'h1b;
  localparam logic [7:0] AffineConst = 8'h63;
  localparam logic [7:0] InvAffineConst = 8'h05;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  function automatic logic [7:0] inv_affine(input logic [7:0] x);
    return {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ InvAffineConst;
  endfunction

  // Inverse S-box derived from the forward table through the inverse affine map.
  function automatic logic [7:0] sub_byte(input logic [7:0] x, input logic dec);
    logic [7:0] y;
    y = SBOX[dec ? inv_affine(x) : x];
    return dec ? inv_affine(y) : y;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic dec);
    logic [7:0] a [4];
    logic [3:0] m [4];
    logic [7:0] v;
    logic [31:0] res;
    res = '0;
    for (int k = 0; k < 4; k++) a[k] = col[31-8*k -: 8];
    if (dec) begin
      m[0] = 4'he; m[1] = 4'hb; m[2] = 4'hd; m[3] = 4'h9;
    end else begin
      m[0] = 4'h2; m[1] = 4'h3; m[2] = 4'h1; m[3] = 4'h1;
    end
    for (int r = 0; r < 4; r++) begin
      v = 8'h00;
      for (int k = 0; k < 4; k++) v = v ^ gmul(a[k], m[(k - r) & 3]);
      res[31-8*r -: 8] = v;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/aes_key_sched.sv
// Word-serial round-key expansion into the round-key register file.
module aes_key_sched (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stale,
  input  aes_pkg::key_size_t    key_size,
  input  logic [63:0]           key_word0,
  input  logic [63:0]           key_word1,
  input  logic [63:0]           key_word2,
  input  logic [63:0]           key_word3,
  output logic                  ready,
  output logic [127:0]          round_keys [aes_pkg::NumRoundKeys]
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'b001,
    ST_RUN   = 3'b010,
    ST_READY = 3'b100
  } sched_state_t;

  sched_state_t state;
  logic [5:0]  widx;
  logic [2:0]  phase;
  logic [7:0]  rcon;
  logic [31:0] win [8];
  logic [31:0] store [NumWords];
  logic [31:0] key32 [8];
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] back;
  logic [31:0] word;

  assign key32[0] = key_word0[63:32];
  assign key32[1] = key_word0[31:0];
  assign key32[2] = key_word1[63:32];
  assign key32[3] = key_word1[31:0];
  assign key32[4] = key_word2[63:32];
  assign key32[5] = key_word2[31:0];
  assign key32[6] = key_word3[63:32];
  assign key32[7] = key_word3[31:0];

  always_comb begin
    case (key_size)
      KEY_128: begin
        nk = 4'd4; total = 6'd44; back = win[3];
      end
      KEY_192: begin
        nk = 4'd6; total = 6'd52; back = win[5];
      end
      default: begin
        nk = 4'd8; total = 6'd60; back = win[7];
      end
    endcase
  end

  always_comb begin
    if (widx < {2'b00, nk}) begin
      word = key32[widx[2:0]];
    end else if (phase == 3'd0) begin
      word = back ^ sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && phase == 3'd4) begin
      word = back ^ sub_word(win[0]);
    end else begin
      word = back ^ win[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
      widx  <= '0;
      phase <= '0;
      rcon  <= 8'h01;
    end else if (stale) begin
      state <= ST_WAIT;
    end else begin
      case (state)
        ST_WAIT: begin
          widx  <= '0;
          phase <= '0;
          rcon  <= 8'h01;
          state <= ST_RUN;
        end
        ST_RUN: begin
          widx  <= widx + 6'd1;
          phase <= (phase == 3'(nk - 4'd1)) ? 3'd0 : phase + 3'd1;
          if (widx >= {2'b00, nk} && phase == 3'd0) rcon <= xtime(rcon);
          if (widx == total - 6'd1) state <= ST_READY;
        end
        ST_READY: begin
          state <= ST_READY;
        end
        default: begin
          state <= ST_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      store[widx] <= word;
      win[0] <= word;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
    end
  end

  generate
    for (genvar g = 0; g < NumRoundKeys; g++) begin : g_rk
      assign round_keys[g] = {store[4*g], store[4*g+1], store[4*g+2], store[4*g+3]};
    end
  endgenerate

  assign ready = (state == ST_READY);

  a_widx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> widx < 6'(NumWords))
    else $error("key word index past store");
  a_ready_stale: assert property (@(posedge clk) disable iff (rst)
    stale |=> !ready)
    else $error("schedule marked ready after key change");
  a_run_advance: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && !stale |=> widx == $past(widx) + 6'd1)
    else $error("expansion did not advance");

endmodule

FILE: hw/rtl/aes_round.sv
// One registered AES round stage, encrypt or decrypt, full, final or bypass.
module aes_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  aes_pkg::round_ctrl_t ctrl,
  input  logic [127:0]        round_key,
  input  logic                in_valid,
  input  logic [127:0]        in_state,
  output logic                out_valid,
  output logic [127:0]        out_state
);
  import aes_pkg::*;

  logic [7:0]   sb [16];
  logic [7:0]   sh [16];
  logic [127:0] shv;
  logic [127:0] keyed;
  logic [127:0] mixed;
  logic [127:0] res;

  always_comb begin
    for (int n = 0; n < 16; n++) sb[n] = sub_byte(in_state[127-8*n -: 8], ctrl.dec);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.dec) begin
          sh[4*((c+r)&3)+r] = sb[4*c+r];
        end else begin
          sh[4*c+r] = sb[4*((c+r)&3)+r];
        end
      end
    end
    for (int n = 0; n < 16; n++) shv[127-8*n -: 8] = sh[n];
  end

  always_comb begin
    keyed = shv ^ round_key;
    for (int c = 0; c < 4; c++) begin
      mixed[127-32*c -: 32] = ctrl.dec ? mix_col(keyed[127-32*c -: 32], 1'b1)
                                       : mix_col(shv[127-32*c -: 32], 1'b0)
                                         ^ round_key[127-32*c -: 32];
    end
    if (ctrl.full) begin
      res = mixed;
    end else if (ctrl.last) begin
      res = keyed;
    end else begin
      res = in_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_state <= res;
  end

endmodule

FILE: hw/rtl/aes_block_cipher_ecb.sv
// AES-128/192/256 ECB block cipher, one round per pipeline stage.
//
//  port group   dir  payload
//  s_*          in   tdata[63:0] block_high, [127:64] block_low
//  m_*          out  tdata[63:0] result_high, [127:64] result_low
//  p*           cfg  key_word0..3, key_size, decrypt_mode at 8*i
//
// Every key size takes the same path, the key-addition stage plus 14 round stages;
// one block may enter each cycle while the output is not held and the keys are ready.
// After reset or a key or key_size write, the key expansion produces one word per
// cycle until all 44, 52 or 60 words are stored; s_tready stays low meanwhile.
// A held output stalls the whole pipe in place; nothing is dropped.
module aes_block_cipher_ecb (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // block_high, block_low
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // result_high, result_low
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import aes_pkg::*;

  localparam int NumStages = 14;

  logic [63:0]  key_word0;
  logic [63:0]  key_word1;
  logic [63:0]  key_word2;
  logic [63:0]  key_word3;
  key_size_t    key_size;
  logic         decrypt_mode;
  logic         wr;
  logic         stale;
  logic         ready;
  logic [127:0] round_keys [NumRoundKeys];
  logic [3:0]   nr;
  logic         en;
  logic         in_valid;
  logic [127:0] in_state;
  logic         v [NumStages + 1];
  logic [127:0] st [NumStages + 1];

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign stale = wr && (paddr[5:3] == REG_KEY0 || paddr[5:3] == REG_KEY1 ||
                        paddr[5:3] == REG_KEY2 || paddr[5:3] == REG_KEY3 ||
                        paddr[5:3] == REG_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0    <= '0;
      key_word1    <= '0;
      key_word2    <= '0;
      key_word3    <= '0;
      key_size     <= KEY_128;
      decrypt_mode <= 1'b0;
    end else if (wr) begin
      case (paddr[5:3])
        REG_KEY0: key_word0 <= pwdata;
        REG_KEY1: key_word1 <= pwdata;
        REG_KEY2: key_word2 <= pwdata;
        REG_KEY3: key_word3 <= pwdata;
        REG_SIZE: key_size <= key_size_t'(pwdata[1:0]);
        REG_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_KEY0: prdata = key_word0;
      REG_KEY1: prdata = key_word1;
      REG_KEY2: prdata = key_word2;
      REG_KEY3: prdata = key_word3;
      REG_SIZE: prdata = {62'h0, key_size};
      REG_MODE: prdata = {63'h0, decrypt_mode};
      default:  prdata = '0;
    endcase
  end

  aes_key_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .stale      (stale),
    .key_size   (key_size),
    .key_word0  (key_word0),
    .key_word1  (key_word1),
    .key_word2  (key_word2),
    .key_word3  (key_word3),
    .ready      (ready),
    .round_keys (round_keys)
  );

  always_comb begin
    case (key_size)
      KEY_128: nr = 4'd10;
      KEY_192: nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end

  assign en       = !v[NumStages] || m_tready;
  assign s_tready = en && ready;
  assign in_valid = s_tvalid && s_tready;
  assign in_state = {s_tdata[63:0], s_tdata[127:64]};

  // initial key addition
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!decrypt_mode) begin
        st[0] <= in_state ^ round_keys[0];
      end else begin
        case (key_size)
          KEY_128: st[0] <= in_state ^ round_keys[10];
          KEY_192: st[0] <= in_state ^ round_keys[12];
          default: st[0] <= in_state ^ round_keys[14];
        endcase
      end
    end
  end

  generate
    for (genvar k = 1; k <= NumStages; k++) begin : g_round
      localparam int D10 = (k > 10) ? 0 : 10 - k;
      localparam int D12 = (k > 12) ? 0 : 12 - k;
      localparam int D14 = 14 - k;
      round_ctrl_t  ctrl;
      logic [127:0] rk;

      always_comb begin
        ctrl.dec  = decrypt_mode;
        ctrl.full = 4'(k) < nr;
        ctrl.last = 4'(k) == nr;
        if (!decrypt_mode) begin
          rk = round_keys[k];
        end else begin
          case (key_size)
            KEY_128: rk = round_keys[D10];
            KEY_192: rk = round_keys[D12];
            default: rk = round_keys[D14];
          endcase
        end
      end

      aes_round u_round (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .ctrl      (ctrl),
        .round_key (rk),
        .in_valid  (v[k-1]),
        .in_state  (st[k-1]),
        .out_valid (v[k]),
        .out_state (st[k])
      );
    end
  endgenerate

  assign m_tvalid = v[NumStages];
  assign m_tdata  = {st[NumStages][63:0], st[NumStages][127:64]};

  a_no_accept_unready: assert property (@(posedge clk) disable iff (rst)
    !ready |-> !s_tready)
    else $error("input taken before key schedule ready");
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(v[0]))
    else $error("pipe moved under stall");
  a_entry_tracks: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> v[0])
    else $error("accepted block not in first stage");

endmodule
